// ===== rtl/disjoint_set_union_find_defines.svh =====
// Assertion macros used by the checker of the disjoint-set block.
// Depends on nothing; include it by its bare file name.
`ifndef DISJOINT_SET_UNION_FIND_DEFINES_SVH
`define DISJOINT_SET_UNION_FIND_DEFINES_SVH

// The consequent must hold in the cycle after the antecedent.
`define DSU_ASSERT_NEXT(lbl, clk, rstn, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (pre) |=> (post)) \
        else $error("dsu: next-cycle check failed");

// The consequent must hold in the same cycle as the antecedent.
`define DSU_ASSERT_NOW(lbl, clk, rstn, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (pre) |-> (post)) \
        else $error("dsu: same-cycle check failed");

`endif

// ===== rtl/dsu_pkg.sv =====
// Shared types and constants of the disjoint-set block.
// Used by the controller, the datapath, the top level and the checker.
package dsu_pkg;

    localparam int ELEMENTS = 1024;
    localparam int IDX_W    = 10;
    localparam int SIZE_W   = 11;
    localparam int CMD_W    = 2;

    localparam logic [CMD_W-1:0] CMD_UNITE = 2'd0;
    localparam logic [CMD_W-1:0] CMD_QUERY = 2'd1;
    localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd2;

    typedef logic [IDX_W-1:0]  idx_t;
    typedef logic [SIZE_W-1:0] size_t;

    typedef struct packed {
        logic [CMD_W-1:0] command;
        idx_t             first_index;
        idx_t             second_index;
    } in_item_t;

    typedef struct packed {
        logic  same_set;
        idx_t  root_of_first;
        size_t set_size;
        idx_t  set_min;
        idx_t  set_max;
    } out_item_t;

    typedef struct packed {
        logic  root;
        idx_t  parent;
        size_t count;
        idx_t  lo;
        idx_t  hi;
    } node_t;

    typedef enum logic [3:0] {
        ST_INIT_SWEEP,
        ST_IDLE,
        ST_DECODE,
        ST_CLR_SWEEP,
        ST_WALK_ISSUE,
        ST_WALK,
        ST_CMP_ISSUE,
        ST_CMP,
        ST_LINK_KEEP,
        ST_LINK_DROP,
        ST_DONE
    } dsu_state_t;

    typedef enum logic [3:0] {
        DP_IDLE,
        DP_SWEEP,
        DP_WALK_ISSUE,
        DP_WALK,
        DP_CMP_ISSUE,
        DP_CMP,
        DP_LINK_KEEP,
        DP_LINK_DROP,
        DP_PUBLISH
    } dp_op_t;

    typedef struct packed {
        dp_op_t op;
        logic   accept;
        logic   second;
    } dp_cmd_t;

    typedef struct packed {
        logic is_clear;
        logic is_bad;
        logic at_root;
        logic trivial;
        logic cmp_last;
        logic sweep_last;
        logic merge;
        logic out_free;
    } dp_status_t;

endpackage

// ===== rtl/disjoint_set_union_find.sv =====
// Top level of the disjoint-set block: union by size with path compression.
// Depends on dsu_pkg, dsu_ctrl and dsu_datapath.
//
// Items enter on s_valid/s_ready as an in_item_t (command, first_index,
// second_index); one result leaves per item on m_valid/m_ready as an out_item_t.
// A unite merges two sets, a query reports the first element's set and whether
// the second element shares it, and a clear makes every element a singleton.
// Items are handled one at a time. A unite or query walks the parent chain
// of each element to its root, then walks it again to point every node on it
// at the root, and a unite that finds two roots links them by writing both
// root nodes; then the result is registered, and the next item can be accepted
// in the cycle after that. After compression chains are short. Each chain step
// is one read of the node memory, which has a read and a write port, and
// every compression step also writes it. A clear rewrites all 1024 nodes, one
// per cycle, before its result is registered; an unused command goes straight
// to its result. After reset the same clearing pass runs with s_ready low.
// The result sits in an output register: a new item is accepted while an
// earlier result still waits, and a stalled receiver only holds the block
// at the point where the next result is ready to be registered.
module disjoint_set_union_find import dsu_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  in_item_t  s_data,
    output logic      m_valid,
    input  logic      m_ready,
    output out_item_t m_data
);

    dp_cmd_t    cmd;
    dp_status_t status;

    dsu_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    dsu_datapath u_datapath (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_data  (s_data),
        .cmd     (cmd),
        .m_ready (m_ready),
        .m_valid (m_valid),
        .m_data  (m_data),
        .status  (status)
    );

endmodule

// ===== rtl/dsu_ctrl.sv =====
// Controller state machine of the disjoint-set block.
// Depends on dsu_pkg; drives the datapath through dp_cmd_t and reads dp_status_t.
module dsu_ctrl import dsu_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  dp_status_t status,
    output dp_cmd_t    cmd
);

    dsu_state_t state_reg, state_next;
    logic       side_reg, side_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_INIT_SWEEP;
            side_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            side_reg  <= side_next;
        end
    end

    always_comb begin
        dsu_state_t after_find;
        after_find = side_reg ? (status.merge ? ST_LINK_KEEP : ST_DONE) : ST_WALK_ISSUE;
        state_next = state_reg;
        side_next  = side_reg;
        case (state_reg)
            ST_INIT_SWEEP: begin
                if (status.sweep_last) state_next = ST_IDLE;
            end
            ST_IDLE: begin
                if (s_valid) state_next = ST_DECODE;
            end
            ST_DECODE: begin
                side_next = 1'b0;
                if (status.is_clear) state_next = ST_CLR_SWEEP;
                else if (status.is_bad) state_next = ST_DONE;
                else state_next = ST_WALK_ISSUE;
            end
            ST_CLR_SWEEP: begin
                if (status.sweep_last) state_next = ST_DONE;
            end
            ST_WALK_ISSUE: begin
                state_next = ST_WALK;
            end
            ST_WALK: begin
                if (status.at_root) state_next = ST_CMP_ISSUE;
            end
            ST_CMP_ISSUE: begin
                if (status.trivial) begin
                    state_next = after_find;
                    side_next  = 1'b1;
                end else begin
                    state_next = ST_CMP;
                end
            end
            ST_CMP: begin
                if (status.cmp_last) begin
                    state_next = after_find;
                    side_next  = 1'b1;
                end
            end
            ST_LINK_KEEP: begin
                state_next = ST_LINK_DROP;
            end
            ST_LINK_DROP: begin
                state_next = ST_DONE;
            end
            ST_DONE: begin
                if (status.out_free) state_next = ST_IDLE;
            end
            default: begin
                state_next = ST_INIT_SWEEP;
            end
        endcase
    end

    always_comb begin
        s_ready    = 1'b0;
        cmd.op     = DP_IDLE;
        cmd.accept = 1'b0;
        cmd.second = side_reg;
        case (state_reg)
            ST_INIT_SWEEP: cmd.op = DP_SWEEP;
            ST_IDLE: begin
                s_ready    = 1'b1;
                cmd.accept = s_valid;
            end
            ST_DECODE:     cmd.op = DP_IDLE;
            ST_CLR_SWEEP:  cmd.op = DP_SWEEP;
            ST_WALK_ISSUE: cmd.op = DP_WALK_ISSUE;
            ST_WALK:       cmd.op = DP_WALK;
            ST_CMP_ISSUE:  cmd.op = DP_CMP_ISSUE;
            ST_CMP:        cmd.op = DP_CMP;
            ST_LINK_KEEP:  cmd.op = DP_LINK_KEEP;
            ST_LINK_DROP:  cmd.op = DP_LINK_DROP;
            ST_DONE:       cmd.op = DP_PUBLISH;
            default:       cmd.op = DP_IDLE;
        endcase
    end

endmodule

// ===== rtl/dsu_datapath.sv =====
// Datapath of the disjoint-set block: node memory, walk and link registers, result register.
// Depends on dsu_pkg; sequenced by dsu_ctrl through dp_cmd_t.
module dsu_datapath import dsu_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  in_item_t   s_data,
    input  dp_cmd_t    cmd,
    input  logic       m_ready,
    output logic       m_valid,
    output out_item_t  m_data,
    output dp_status_t status
);

    node_t     mem [ELEMENTS];
    node_t     rd_word_reg;
    in_item_t  item_reg;
    idx_t      cur_reg, cur_next;
    idx_t      sweep_reg, sweep_next;
    idx_t      root_a_reg, root_b_reg;
    node_t     info_a_reg, info_b_reg;
    out_item_t out_reg;
    logic      out_valid_reg, out_valid_next;

    logic      we;
    idx_t      wa, ra;
    node_t     wd;
    idx_t      sel_index, sel_root;
    logic      same, keep_b, in_range_a, in_range_b;
    idx_t      keep_root, drop_root;
    node_t     merged, drop_word;
    out_item_t result;

    assign sel_index  = cmd.second ? item_reg.second_index : item_reg.first_index;
    assign sel_root   = cmd.second ? root_b_reg : root_a_reg;
    assign same       = root_a_reg == root_b_reg;
    assign keep_b     = info_a_reg.count < info_b_reg.count;
    assign keep_root  = keep_b ? root_b_reg : root_a_reg;
    assign drop_root  = keep_b ? root_a_reg : root_b_reg;
    assign in_range_a = int'(item_reg.first_index) < ELEMENTS;
    assign in_range_b = int'(item_reg.second_index) < ELEMENTS;

    always_comb begin
        merged.root   = 1'b1;
        merged.parent = keep_root;
        merged.count  = info_a_reg.count + info_b_reg.count;
        merged.lo     = (info_a_reg.lo < info_b_reg.lo) ? info_a_reg.lo : info_b_reg.lo;
        merged.hi     = (info_a_reg.hi > info_b_reg.hi) ? info_a_reg.hi : info_b_reg.hi;
        drop_word        = keep_b ? info_a_reg : info_b_reg;
        drop_word.root   = 1'b0;
        drop_word.parent = keep_root;
    end

    always_comb begin
        we       = 1'b0;
        wa       = cur_reg;
        wd       = rd_word_reg;
        ra       = cur_reg;
        cur_next = cur_reg;
        case (cmd.op)
            DP_SWEEP: begin
                we = 1'b1;
                wa = sweep_reg;
                wd = '{root: 1'b1, parent: sweep_reg, count: size_t'(1),
                       lo: sweep_reg, hi: sweep_reg};
            end
            DP_WALK_ISSUE, DP_CMP_ISSUE: begin
                ra       = sel_index;
                cur_next = sel_index;
            end
            DP_WALK: begin
                ra       = rd_word_reg.parent;
                cur_next = rd_word_reg.parent;
            end
            DP_CMP: begin
                we        = 1'b1;
                wa        = cur_reg;
                wd.parent = sel_root;
                ra        = rd_word_reg.parent;
                cur_next  = rd_word_reg.parent;
            end
            DP_LINK_KEEP: begin
                we = 1'b1;
                wa = keep_root;
                wd = merged;
            end
            DP_LINK_DROP: begin
                we = 1'b1;
                wa = drop_root;
                wd = drop_word;
            end
            default: begin
                we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (we) mem[wa] <= wd;
        rd_word_reg <= mem[ra];
    end

    always_comb begin
        if (item_reg.command == CMD_CLEAR) begin
            if (in_range_a) begin
                result = '{same_set: 1'b0, root_of_first: item_reg.first_index,
                           set_size: size_t'(1), set_min: item_reg.first_index,
                           set_max: item_reg.first_index};
            end else begin
                result = '0;
            end
        end else if (status.is_bad) begin
            result = '0;
        end else if (status.merge) begin
            result = '{same_set: 1'b0, root_of_first: keep_root, set_size: merged.count,
                       set_min: merged.lo, set_max: merged.hi};
        end else begin
            result = '{same_set: same, root_of_first: root_a_reg, set_size: info_a_reg.count,
                       set_min: info_a_reg.lo, set_max: info_a_reg.hi};
        end
    end

    always_comb begin
        status.is_clear   = item_reg.command == CMD_CLEAR;
        status.is_bad     = !((item_reg.command == CMD_UNITE) || (item_reg.command == CMD_QUERY))
                            || !in_range_a || !in_range_b;
        status.at_root    = rd_word_reg.root;
        status.trivial    = sel_index == sel_root;
        status.cmp_last   = rd_word_reg.parent == sel_root;
        status.sweep_last = sweep_reg == idx_t'(ELEMENTS - 1);
        status.merge      = (item_reg.command == CMD_UNITE) && !same;
        status.out_free   = !out_valid_reg || m_ready;
    end

    always_comb begin
        sweep_next = sweep_reg;
        if (cmd.op == DP_SWEEP) begin
            sweep_next = status.sweep_last ? '0 : sweep_reg + idx_t'(1);
        end
        out_valid_next = out_valid_reg;
        if ((cmd.op == DP_PUBLISH) && status.out_free) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sweep_reg     <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            sweep_reg     <= sweep_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        cur_reg <= cur_next;
        if (cmd.accept) item_reg <= s_data;
        if ((cmd.op == DP_WALK) && rd_word_reg.root) begin
            if (cmd.second) begin
                root_b_reg <= cur_reg;
                info_b_reg <= rd_word_reg;
            end else begin
                root_a_reg <= cur_reg;
                info_a_reg <= rd_word_reg;
            end
        end
        if ((cmd.op == DP_PUBLISH) && status.out_free) out_reg <= result;
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;

endmodule

// ===== rtl/dsu_checker.sv =====
// Port-level checker of the disjoint-set block, bound to the top level.
// Depends on dsu_pkg and disjoint_set_union_find_defines.svh.
`include "disjoint_set_union_find_defines.svh"

module dsu_checker import dsu_pkg::*; (
    input logic      aclk,
    input logic      aresetn,
    input logic      s_valid,
    input logic      s_ready,
    input logic      m_valid,
    input logic      m_ready,
    input out_item_t m_data
);

    `DSU_ASSERT_NEXT(a_hold_result, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_data))

    `DSU_ASSERT_NEXT(a_busy_after_accept, aclk, aresetn, s_valid && s_ready, !s_ready)

    `DSU_ASSERT_NOW(a_root_within_bounds, aclk, aresetn, m_valid && (m_data.set_size != '0),
        (m_data.set_min <= m_data.root_of_first) && (m_data.root_of_first <= m_data.set_max))

    `DSU_ASSERT_NOW(a_singleton_shape, aclk, aresetn, m_valid && (m_data.set_size == size_t'(1)),
        (m_data.set_min == m_data.set_max) && (m_data.root_of_first == m_data.set_min))

endmodule

bind disjoint_set_union_find dsu_checker u_dsu_checker (.*);

// ===== verif/tb.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for disjoint_set_union_find: directed and random commands
// run against an in-order model of the set forest. Depends on dsu_pkg and the RTL.
module tb;
    import dsu_pkg::*;

    localparam logic [CMD_W-1:0] CMD_RESERVED = 2'd3;
    localparam int MAX_WAIT = 18;
    localparam int QUIET_LIMIT = 10000;

    logic      aclk = 1'b0;
    logic      aresetn;
    logic      s_valid;
    logic      s_ready;
    in_item_t  s_data;
    logic      m_valid;
    logic      m_ready;
    out_item_t m_data;

    idx_t  link_to [ELEMENTS];
    bit    is_root [ELEMENTS];
    size_t members [ELEMENTS];
    idx_t  low_of  [ELEMENTS];
    idx_t  high_of [ELEMENTS];

    out_item_t pending_results[$];
    int        mismatch_count = 0;
    int        quiet_cycles = 0;
    bit        idle_on = 1'b1;

    disjoint_set_union_find uut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    always #1 aclk = ~aclk;

    function automatic void reset_forest();
        for (int e = 0; e < ELEMENTS; e++) begin
            link_to[e] = idx_t'(e);
            is_root[e] = 1'b1;
            members[e] = size_t'(1);
            low_of[e]  = idx_t'(e);
            high_of[e] = idx_t'(e);
        end
    endfunction

    function automatic idx_t find_root(idx_t e);
        idx_t r;
        idx_t up;
        r = e;
        while (!is_root[r]) r = link_to[r];
        while (e != r) begin
            up = link_to[e];
            link_to[e] = r;
            e = up;
        end
        return r;
    endfunction

    function automatic out_item_t apply_command(in_item_t it);
        out_item_t res;
        idx_t ra, rb, keep, drop;
        res = '0;
        case (it.command)
            CMD_CLEAR: begin
                reset_forest();
                res.root_of_first = it.first_index;
                res.set_size = size_t'(1);
                res.set_min = it.first_index;
                res.set_max = it.first_index;
            end
            CMD_UNITE, CMD_QUERY: begin
                ra = find_root(it.first_index);
                rb = find_root(it.second_index);
                res.same_set = (ra == rb);
                if (it.command == CMD_UNITE && ra != rb) begin
                    keep = ra;
                    drop = rb;
                    if (members[ra] < members[rb]) begin
                        keep = rb;
                        drop = ra;
                    end
                    members[keep] = members[keep] + members[drop];
                    if (low_of[drop] < low_of[keep]) low_of[keep] = low_of[drop];
                    if (high_of[drop] > high_of[keep]) high_of[keep] = high_of[drop];
                    link_to[drop] = keep;
                    is_root[drop] = 1'b0;
                    ra = keep;
                end
                res.root_of_first = ra;
                res.set_size = members[ra];
                res.set_min = low_of[ra];
                res.set_max = high_of[ra];
            end
            default: begin
            end
        endcase
        return res;
    endfunction

    task automatic send_command(input logic [CMD_W-1:0] op, input idx_t a, input idx_t b);
        int gap;
        in_item_t it;
        it.command = op;
        it.first_index = a;
        it.second_index = b;
        gap = idle_on ? $urandom_range(0, MAX_WAIT) : 0;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_data <= it;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        pending_results = {pending_results, apply_command(it)};
        @(negedge aclk);
    endtask

    task automatic check_field(input string name, input logic [SIZE_W-1:0] want,
                               input logic [SIZE_W-1:0] got);
        if (want !== got) begin
            $display("%0t ns: %s expected %0d, got %0d", $time, name, want, got);
            mismatch_count++;
        end
    endtask

    always @(posedge aclk) begin : result_check
        out_item_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_results.size() == 0) begin
                $display("%0t ns: result expected none, got %p", $time, m_data);
                mismatch_count++;
            end else begin
                want = pending_results.pop_front();
                check_field("same_set", SIZE_W'(want.same_set), SIZE_W'(m_data.same_set));
                check_field("root_of_first", SIZE_W'(want.root_of_first),
                            SIZE_W'(m_data.root_of_first));
                check_field("set_size", want.set_size, m_data.set_size);
                check_field("set_min", SIZE_W'(want.set_min), SIZE_W'(m_data.set_min));
                check_field("set_max", SIZE_W'(want.set_max), SIZE_W'(m_data.set_max));
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    initial begin : result_drain
        int hold;
        m_ready = 1'b0;
        @(posedge aresetn);
        @(negedge aclk);
        forever begin
            hold = idle_on ? $urandom_range(0, MAX_WAIT) : 0;
            if (hold > 0) begin
                m_ready <= 1'b0;
                @(posedge aclk);
                while (!m_valid) @(posedge aclk);
                repeat (hold) @(negedge aclk);
            end
            m_ready <= 1'b1;
            @(posedge aclk);
            while (!m_valid) @(posedge aclk);
            @(negedge aclk);
        end
    end

    task automatic test_corner_indices();
        send_command(CMD_UNITE, idx_t'(0), idx_t'(ELEMENTS - 1));
        send_command(CMD_QUERY, idx_t'(ELEMENTS - 1), idx_t'(0));
        send_command(CMD_QUERY, idx_t'(0), idx_t'(0));
        send_command(CMD_QUERY, idx_t'(512), idx_t'(511));
    endtask

    task automatic test_unite_rules();
        send_command(CMD_UNITE, idx_t'(ELEMENTS - 1), idx_t'(0));
        send_command(CMD_UNITE, idx_t'(5), idx_t'(6));
        send_command(CMD_UNITE, idx_t'(7), idx_t'(5));
        send_command(CMD_UNITE, idx_t'(0), idx_t'(6));
        send_command(CMD_UNITE, idx_t'(682), idx_t'(341));
    endtask

    task automatic test_reserved_command();
        send_command(CMD_RESERVED, idx_t'(ELEMENTS - 1), idx_t'(ELEMENTS - 1));
        send_command(CMD_RESERVED, idx_t'(0), idx_t'(0));
        send_command(CMD_QUERY, idx_t'(7), idx_t'(ELEMENTS - 1));
    endtask

    task automatic test_clear();
        send_command(CMD_CLEAR, idx_t'(ELEMENTS - 1), idx_t'(0));
        send_command(CMD_QUERY, idx_t'(5), idx_t'(6));
        send_command(CMD_CLEAR, idx_t'(0), idx_t'(ELEMENTS - 1));
        send_command(CMD_UNITE, idx_t'(3), idx_t'(3));
    endtask

    // Pairwise merges of equal-size sets give the deepest chains union by size allows.
    task automatic test_deep_trees(input int rounds);
        int base;
        int stride;
        for (int r = 0; r < rounds; r++) begin
            idle_on = $urandom_range(0, 2) != 0;
            base = $urandom_range(0, ELEMENTS - 64);
            send_command(CMD_CLEAR, idx_t'(base), idx_t'($urandom_range(0, ELEMENTS - 1)));
            stride = 1;
            while (stride < 64) begin
                for (int i = 0; i < 64; i += 2 * stride) begin
                    send_command(CMD_UNITE, idx_t'(base + i), idx_t'(base + i + stride));
                end
                stride = stride * 2;
            end
            repeat (20) begin
                send_command(CMD_QUERY, idx_t'(base + $urandom_range(0, 63)),
                             idx_t'(base + $urandom_range(0, 63)));
            end
        end
    endtask

    task automatic test_random_mix(input int count);
        int base, span, pick, seg_left;
        idx_t a, b;
        logic [CMD_W-1:0] op;
        seg_left = 0;
        base = 0;
        span = ELEMENTS;
        for (int n = 0; n < count; n++) begin
            if (seg_left == 0) begin
                seg_left = $urandom_range(20, 80);
                base = $urandom_range(0, ELEMENTS - 1);
                pick = $urandom_range(0, 9);
                span = (pick < 4) ? 8 : (pick < 7) ? 32 : (pick < 9) ? 128 : ELEMENTS;
                idle_on = $urandom_range(0, 4) != 0;
            end
            seg_left--;
            a = idx_t'(base + $urandom_range(0, span - 1));
            b = idx_t'(base + $urandom_range(0, span - 1));
            if ($urandom_range(0, 19) == 0) a = idx_t'($urandom_range(0, ELEMENTS - 1));
            if ($urandom_range(0, 19) == 0) b = idx_t'($urandom_range(0, ELEMENTS - 1));
            pick = $urandom_range(0, 199);
            if (pick < 3) begin
                op = CMD_CLEAR;
            end else if (pick < 10) begin
                op = CMD_RESERVED;
            end else if (pick < 100) begin
                op = CMD_UNITE;
            end else begin
                op = CMD_QUERY;
            end
            send_command(op, a, b);
        end
    endtask

    initial begin
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_data = '0;
        reset_forest();
        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        test_corner_indices();
        test_unite_rules();
        test_reserved_command();
        test_clear();
        test_deep_trees(6);
        test_random_mix(1050);
        s_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (40) @(posedge aclk);
        if (mismatch_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end
endmodule

// ===== disjoint_set_union_find.f =====
+incdir+rtl
rtl/dsu_pkg.sv
rtl/dsu_ctrl.sv
rtl/dsu_datapath.sv
rtl/disjoint_set_union_find.sv
rtl/dsu_checker.sv
verif/tb.sv
